// File: src/tisg_pkg.sv
package tisg_pkg;

  // SipHash-2-4 over a 38-byte tuple: five message words and 14 rounds in all
  localparam int unsigned NumRounds = 14;
  localparam int unsigned NumWords  = 5;
  localparam int unsigned NumBytes  = 8 * NumWords;
  localparam int unsigned MsgBytes  = 38;
  localparam int unsigned FlatBits  = 8 * MsgBytes;
  localparam logic [7:0]  MsgLen    = 8'(MsgBytes);

  localparam logic [63:0] Iv0 = 64'h736f_6d65_7073_6575;
  localparam logic [63:0] Iv1 = 64'h646f_7261_6e64_6f6d;
  localparam logic [63:0] Iv2 = 64'h6c79_6765_6e65_7261;
  localparam logic [63:0] Iv3 = 64'h7465_6462_7974_6573;
  localparam logic [63:0] FinalXor = 64'h0000_0000_0000_00ff;

  // round of the final word and the one where finalisation starts
  localparam int unsigned LastBlockRound = 8;
  localparam int unsigned FinalRound     = 10;

  // clock component
  localparam logic [63:0] TicksPerMs   = 64'd250;
  localparam logic [63:0] TickMax      = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] TimeSatLimit = TickMax / TicksPerMs;

  // configuration register indexes
  typedef enum logic [0:0] {
    RegKeyLow  = 1'b0,
    RegKeyHigh = 1'b1
  } cfg_reg_e;

  // input item, first field in the highest bits
  typedef struct packed {
    logic [63:0] time_ms;
    logic [7:0]  protocol_number;
    logic [15:0] dest_port;
    logic [15:0] src_port;
    logic [63:0] dest_address_lower;
    logic [63:0] dest_address_upper;
    logic [63:0] source_address_lower;
    logic [63:0] source_address_upper;
    logic [7:0]  address_family;
  } tuple_t;

  typedef logic [NumWords-1:0][63:0] msg_words_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  // one register stage of the hash pipeline
  typedef struct packed {
    sip_state_t  v;
    msg_words_t  m;
    logic [63:0] tick;
  } stage_t;

  // item passed from the hash pipeline to the tick stage
  typedef struct packed {
    logic [31:0] hash;
    logic [63:0] tick;
  } item_t;

  function automatic logic [63:0] rotl(logic [63:0] x, int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

  function automatic sip_state_t sip_round(sip_state_t s);
    sip_state_t t;
    t = s;
    t.v0 = t.v0 + t.v1; t.v1 = rotl(t.v1, 13); t.v1 = t.v1 ^ t.v0; t.v0 = rotl(t.v0, 32);
    t.v2 = t.v2 + t.v3; t.v3 = rotl(t.v3, 16); t.v3 = t.v3 ^ t.v2;
    t.v0 = t.v0 + t.v3; t.v3 = rotl(t.v3, 21); t.v3 = t.v3 ^ t.v0;
    t.v2 = t.v2 + t.v1; t.v1 = rotl(t.v1, 17); t.v1 = t.v1 ^ t.v2; t.v2 = rotl(t.v2, 32);
    return t;
  endfunction

  // word mixing and the finalisation constant ahead of round k, then the round itself
  function automatic stage_t step_stage(stage_t s, int unsigned k);
    stage_t t;
    t = s;
    if ((k % 2) == 0 && k <= LastBlockRound) begin
      if (k >= 2) begin
        t.v.v0 = t.v.v0 ^ t.m[k/2 - 1];
      end
      t.v.v3 = t.v.v3 ^ t.m[k/2];
    end
    if (k == FinalRound) begin
      t.v.v0 = t.v.v0 ^ t.m[NumWords-1];
      t.v.v2 = t.v.v2 ^ FinalXor;
    end
    t.v = sip_round(t.v);
    return t;
  endfunction

  // byte string in network order, then little-endian message words
  function automatic msg_words_t pack_msg(tuple_t tp);
    logic [FlatBits-1:0]         flat;
    logic [NumBytes-1:0][7:0]    bytes;
    msg_words_t                  w;
    flat = {tp.address_family, tp.source_address_upper, tp.source_address_lower,
            tp.dest_address_upper, tp.dest_address_lower, tp.src_port,
            tp.dest_port, tp.protocol_number};
    bytes = '0;
    for (int unsigned i = 0; i < MsgBytes; i++) begin
      bytes[i] = flat[FlatBits - 1 - 8*i -: 8];
    end
    bytes[NumBytes-1] = MsgLen;
    for (int unsigned b = 0; b < NumWords; b++) begin
      w[b] = bytes[8*b + 7 -: 8];
    end
    return w;
  endfunction

endpackage

// File: src/tisg_front.sv
module tisg_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [63:0]          key_low_i,
  input  logic [63:0]          key_high_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tisg_pkg::tuple_t     in_tuple_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tisg_pkg::item_t      out_item_o
);

  localparam int unsigned Last = tisg_pkg::NumRounds - 1;

  logic [tisg_pkg::NumRounds-1:0] valid_q, valid_d;
  tisg_pkg::stage_t               stage_q [tisg_pkg::NumRounds];
  tisg_pkg::stage_t               stage_d [tisg_pkg::NumRounds];
  tisg_pkg::stage_t               init;
  logic                           advance;

  // whole pipeline moves when its tail is empty or taken
  assign advance    = !valid_q[Last] || out_ready_i;
  assign in_ready_o = advance;

  // keyed initial state, message words and saturated tick candidate
  always_comb begin
    init.v.v0 = tisg_pkg::Iv0 ^ key_low_i;
    init.v.v1 = tisg_pkg::Iv1 ^ key_high_i;
    init.v.v2 = tisg_pkg::Iv2 ^ key_low_i;
    init.v.v3 = tisg_pkg::Iv3 ^ key_high_i;
    init.m    = tisg_pkg::pack_msg(in_tuple_i);
    if (in_tuple_i.time_ms > tisg_pkg::TimeSatLimit) begin
      init.tick = tisg_pkg::TickMax;
    end else begin
      // times 250 as 256 - 4 - 2
      init.tick = (in_tuple_i.time_ms << 8) - (in_tuple_i.time_ms << 2)
                - (in_tuple_i.time_ms << 1);
    end
  end

  // one SipHash round per stage
  always_comb begin
    stage_d[0] = tisg_pkg::step_stage(init, 0);
    valid_d    = {valid_q[Last-1:0], in_valid_i};
  end

  for (genvar k = 1; k < tisg_pkg::NumRounds; k++) begin : g_round
    always_comb begin
      stage_d[k] = tisg_pkg::step_stage(stage_q[k-1], k);
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  // stage payload
  for (genvar k = 0; k < tisg_pkg::NumRounds; k++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (advance) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  // hash out of the last stage, low half only
  always_comb begin
    logic [63:0] h;
    h = stage_q[Last].v.v0 ^ stage_q[Last].v.v1 ^ stage_q[Last].v.v2 ^ stage_q[Last].v.v3;
    out_item_o.hash = h[31:0];
    out_item_o.tick = stage_q[Last].tick;
  end

  assign out_valid_o = valid_q[Last];

endmodule

// File: src/tisg_queue.sv
module tisg_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tisg_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tisg_pkg::item_t out_item_o
);

  // two-entry queue between the hash pipeline and the tick stage
  tisg_pkg::item_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q;
  logic            push, pop;

  assign in_ready_o  = (count_q != 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// File: src/tisg_back.sv
module tisg_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  tisg_pkg::item_t in_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [31:0]     out_isn_o
);

  logic [63:0] last_tick_q, last_tick_d;
  logic        out_valid_q;
  logic [31:0] isn_q, isn_d;
  logic        take;

  // output register doubles as the skid stage
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign take       = in_valid_i && in_ready_o;

  // force the clock to move forward unless already saturated
  always_comb begin
    if (in_item_i.tick <= last_tick_q && last_tick_q != tisg_pkg::TickMax) begin
      last_tick_d = last_tick_q + 64'd1;
    end else begin
      last_tick_d = in_item_i.tick;
    end
    isn_d = in_item_i.hash + last_tick_d[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tick_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        last_tick_q <= last_tick_d;
      end
      if (in_ready_o) begin
        out_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      isn_q <= isn_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_isn_o   = isn_q;

endmodule

// File: src/tcp_isn_siphash_generator_core.sv
// Path: an item goes from acceptance to result valid through the 14-stage
// SipHash round pipeline (its first stage loads on acceptance), one queue stage
// and the tick/output register.
// Throughput: one item per cycle; the round pipeline stalls as a whole only
// when the two-entry queue is full.
// Reset: asynchronous, active low; clears the key words, the last tick and
// all valid and queue state.
module tcp_isn_siphash_generator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write port
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_idx_i,
  input  logic [63:0]  cfg_wdata_i,
  // input items
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // address_family, source_address_upper, source_address_lower, dest_address_upper,
  // dest_address_lower, src_port, dest_port, protocol_number, time_ms
  input  logic [367:0] s_axis_tdata_i,
  // result items
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // initial_sequence
  output logic [31:0]  m_axis_tdata_o
);

  logic [63:0]      key_low_q, key_high_q;
  tisg_pkg::tuple_t tuple;
  logic             fr_valid, fr_ready;
  tisg_pkg::item_t  fr_item;
  logic             bk_valid, bk_ready;
  tisg_pkg::item_t  bk_item;

  assign tuple = tisg_pkg::tuple_t'(s_axis_tdata_i);

  // key registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_we_i) begin
      case (tisg_pkg::cfg_reg_e'(cfg_idx_i))
        tisg_pkg::RegKeyLow:  key_low_q  <= cfg_wdata_i;
        tisg_pkg::RegKeyHigh: key_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  tisg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_low_i   (key_low_q),
    .key_high_i  (key_high_q),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_tuple_i  (tuple),
    .out_valid_o (fr_valid),
    .out_ready_i (fr_ready),
    .out_item_o  (fr_item)
  );

  tisg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fr_valid),
    .in_ready_o  (fr_ready),
    .in_item_i   (fr_item),
    .out_valid_o (bk_valid),
    .out_ready_i (bk_ready),
    .out_item_o  (bk_item)
  );

  tisg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (bk_valid),
    .in_ready_o  (bk_ready),
    .in_item_i   (bk_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_isn_o   (m_axis_tdata_o)
  );

endmodule
